@@ rtl/otrj_pkg.sv @@
// Shared constants, command codes and controller/datapath link types for the trace ring journal.
package otrj_pkg;

    // Ring addressing folds the write sequence by its low bits, so the ring holds 2**ADDR_W words.
    localparam int ADDR_W = 6;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int CNT_W  = 7;
    localparam int DATA_W = 64;
    localparam int SEQ_W  = 64;
    localparam int SES_W  = 32;
    localparam int DROP_W = 32;
    localparam int REQ_W  = 16;
    localparam int ACT_W  = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_RECORD  = 3'd0,
        ACT_DUMP    = 3'd1,
        ACT_DRAIN   = 3'd2,
        ACT_CLEAR   = 3'd3,
        ACT_ENABLE  = 3'd4,
        ACT_DISABLE = 3'd5
    } t_action;

    typedef struct packed {
        logic accept;
        logic catch_up;
        logic size;
        logic plan;
        logic issue;
        logic finish_empty;
    } t_dp_cmd;

    typedef struct packed {
        logic rem_zero;
        logic rem_one;
    } t_dp_stat;

endpackage

@@ rtl/otrj_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module otrj_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/otrj_ctrl.sv @@
// Command sequencer for the trace ring journal: accepts commands and steps dump and drain runs.
module otrj_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [otrj_pkg::ACT_W-1:0] i_action,
    input  otrj_pkg::t_dp_stat        i_stat,
    output otrj_pkg::t_dp_cmd         o_cmd,
    output logic                      o_busy
);
    import otrj_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CATCH,
        ST_SIZE,
        ST_PLAN,
        ST_EMIT
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    cmd.accept = 1'b1;
                    case (t_action'(i_action))
                        ACT_DUMP:  n_state = ST_EMIT;
                        ACT_DRAIN: n_state = ST_CATCH;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CATCH: begin
                cmd.catch_up = 1'b1;
                n_state      = ST_SIZE;
            end
            ST_SIZE: begin
                cmd.size = 1'b1;
                n_state  = ST_PLAN;
            end
            ST_PLAN: begin
                cmd.plan = 1'b1;
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.rem_zero) begin
                    cmd.finish_empty = 1'b1;
                    n_state          = ST_IDLE;
                end else begin
                    cmd.issue = 1'b1;
                    if (i_stat.rem_one) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != ST_IDLE);
endmodule

@@ rtl/otrj_dp.sv @@
// Journal datapath: ring memory, sequence and cursor state, counters and the result register.
module otrj_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  otrj_pkg::t_dp_cmd           i_cmd,
    input  logic [otrj_pkg::ACT_W-1:0]  i_action,
    input  logic [otrj_pkg::DATA_W-1:0] i_record_data,
    input  logic [otrj_pkg::REQ_W-1:0]  i_request_count,
    output otrj_pkg::t_dp_stat          o_stat,
    output logic                        o_valid,
    output logic                        o_has_entry,
    output logic [otrj_pkg::DATA_W-1:0] o_entry_data,
    output logic [otrj_pkg::SEQ_W-1:0]  o_entry_sequence,
    output logic [otrj_pkg::SES_W-1:0]  o_session,
    output logic                        o_last,
    output logic [otrj_pkg::CNT_W-1:0]  o_emitted_total,
    output logic [otrj_pkg::CNT_W-1:0]  o_stored_count,
    output logic [otrj_pkg::DROP_W-1:0] o_dropped_total,
    output logic                        o_is_enabled
);
    import otrj_pkg::*;

    // Architectural state.
    logic [SEQ_W-1:0]  r_ws,      n_ws;
    logic [CNT_W-1:0]  r_fill,    n_fill;
    logic [SEQ_W-1:0]  r_cursor,  n_cursor;
    logic [DROP_W-1:0] r_drop,    n_drop;
    logic [SES_W-1:0]  r_session, n_session;
    logic              r_en,      n_en;

    // Run bookkeeping for dump and drain.
    logic [SEQ_W-1:0]  r_oldest;
    logic [REQ_W-1:0]  r_req;
    logic              r_drain;
    logic              r_lt;
    logic [SEQ_W-1:0]  r_diff;
    logic [SEQ_W-1:0]  r_rd_seq,  n_rd_seq;
    logic [CNT_W-1:0]  r_rem,     n_rem;
    logic [CNT_W-1:0]  r_n,       n_n;

    // Result register.
    logic              r_p_valid, n_p_valid;
    logic              r_p_has,   n_p_has;
    logic              r_p_last,  n_p_last;
    logic [SEQ_W-1:0]  r_p_seq,   n_p_seq;
    logic [CNT_W-1:0]  r_p_total, n_p_total;

    logic              ram_we;
    logic [DATA_W-1:0] ram_q;
    logic [SES_W-1:0]  ses_inc;
    logic [CNT_W-1:0]  dump_want;
    logic [CNT_W-1:0]  avail;
    logic [CNT_W-1:0]  req_lim;
    t_action           act;

    assign act     = t_action'(i_action);
    assign ram_we  = i_cmd.accept && (act == ACT_RECORD) && r_en;
    assign ses_inc = r_session + SES_W'(1);

    assign dump_want = ((i_request_count == '0) || (i_request_count > REQ_W'(r_fill)))
                       ? r_fill : i_request_count[CNT_W-1:0];
    assign avail   = !r_lt ? '0
                   : (r_diff > SEQ_W'(DEPTH)) ? CNT_W'(DEPTH) : r_diff[CNT_W-1:0];
    assign req_lim = ((r_req == '0) || (r_req > REQ_W'(DEPTH)))
                   ? CNT_W'(DEPTH) : r_req[CNT_W-1:0];

    otrj_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ws[ADDR_W-1:0]),
        .i_wdata (i_record_data),
        .i_re    (i_cmd.issue),
        .i_raddr (r_rd_seq[ADDR_W-1:0]),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_ws      = r_ws;
        n_fill    = r_fill;
        n_cursor  = r_cursor;
        n_drop    = r_drop;
        n_session = r_session;
        n_en      = r_en;
        n_rd_seq  = r_rd_seq;
        n_rem     = r_rem;
        n_n       = r_n;
        n_p_valid = 1'b0;
        n_p_has   = 1'b0;
        n_p_last  = 1'b0;
        n_p_seq   = r_p_seq;
        n_p_total = '0;

        if (i_cmd.accept) begin
            n_n = '0;
            // Every command except dump and drain answers with one bare last beat.
            if ((act != ACT_DUMP) && (act != ACT_DRAIN)) begin
                n_p_valid = 1'b1;
                n_p_last  = 1'b1;
            end
            case (act)
                ACT_RECORD: begin
                    if (r_en) begin
                        if ((r_fill >= CNT_W'(DEPTH)) && (r_drop != '1)) begin
                            n_drop = r_drop + DROP_W'(1);
                        end
                        n_ws = r_ws + SEQ_W'(1);
                        if (r_fill < CNT_W'(DEPTH)) begin
                            n_fill = r_fill + CNT_W'(1);
                        end
                    end
                end
                ACT_DUMP: begin
                    n_rem    = dump_want;
                    n_rd_seq = r_ws - SEQ_W'(dump_want);
                end
                ACT_DRAIN: begin
                end
                ACT_CLEAR: begin
                    n_fill   = '0;
                    n_ws     = '0;
                    n_cursor = '0;
                    n_drop   = '0;
                end
                ACT_ENABLE: begin
                    if (!r_en) begin
                        n_session = (ses_inc == '0) ? SES_W'(1) : ses_inc;
                        n_drop    = '0;
                    end
                    n_en     = 1'b1;
                    n_cursor = r_ws;
                end
                ACT_DISABLE: begin
                    if (r_en) begin
                        n_fill   = '0;
                        n_ws     = '0;
                        n_cursor = '0;
                    end
                    n_en = 1'b0;
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.catch_up && (r_cursor < r_oldest)) begin
            n_cursor = r_oldest;
        end

        if (i_cmd.plan) begin
            n_rem    = (avail < req_lim) ? avail : req_lim;
            n_rd_seq = r_cursor;
        end

        if (i_cmd.issue) begin
            n_p_valid = 1'b1;
            n_p_has   = 1'b1;
            n_p_seq   = r_rd_seq;
            n_p_last  = (r_rem == CNT_W'(1));
            n_p_total = (r_rem == CNT_W'(1)) ? (r_n + CNT_W'(1)) : '0;
            n_rd_seq  = r_rd_seq + SEQ_W'(1);
            n_rem     = r_rem - CNT_W'(1);
            n_n       = r_n + CNT_W'(1);
            if (r_drain) begin
                n_cursor = r_rd_seq + SEQ_W'(1);
            end
        end

        if (i_cmd.finish_empty) begin
            n_p_valid = 1'b1;
            n_p_last  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws      <= '0;
            r_fill    <= '0;
            r_cursor  <= '0;
            r_drop    <= '0;
            r_session <= '0;
            r_en      <= 1'b0;
            r_rem     <= '0;
            r_n       <= '0;
            r_p_valid <= 1'b0;
        end else begin
            r_ws      <= n_ws;
            r_fill    <= n_fill;
            r_cursor  <= n_cursor;
            r_drop    <= n_drop;
            r_session <= n_session;
            r_en      <= n_en;
            r_rem     <= n_rem;
            r_n       <= n_n;
            r_p_valid <= n_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_oldest <= r_ws - SEQ_W'(r_fill);
            r_req    <= i_request_count;
            r_drain  <= (act == ACT_DRAIN);
        end
        if (i_cmd.size) begin
            r_lt   <= (r_cursor < r_ws);
            r_diff <= r_ws - r_cursor;
        end
        r_rd_seq  <= n_rd_seq;
        r_p_has   <= n_p_has;
        r_p_last  <= n_p_last;
        r_p_seq   <= n_p_seq;
        r_p_total <= n_p_total;
    end

    assign o_stat.rem_zero = (r_rem == '0);
    assign o_stat.rem_one  = (r_rem == CNT_W'(1));

    assign o_valid          = r_p_valid;
    assign o_has_entry      = r_p_has;
    assign o_entry_data     = r_p_has ? ram_q : '0;
    assign o_entry_sequence = r_p_has ? r_p_seq : '0;
    assign o_last           = r_p_last;
    assign o_emitted_total  = r_p_total;
    assign o_session        = r_session;
    assign o_stored_count   = r_fill;
    assign o_dropped_total  = r_drop;
    assign o_is_enabled     = r_en;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(DEPTH))
        else $error("stored count exceeds ring depth");

    a_disabled_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_en |-> (r_fill == '0))
        else $error("ring holds entries while disabled");

    a_session_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_en |-> (r_session != '0))
        else $error("enabled with a zero session");

    a_bare_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_valid && !r_p_has) |-> r_p_last)
        else $error("beat without entry is not the last beat");

    a_issue_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |=> (r_n == $past(r_n) + CNT_W'(1)))
        else $error("emitted count did not advance on a read");
endmodule

@@ rtl/overwriting_trace_ring_journal_top.sv @@
// Top level of the overwriting trace ring journal: sequencer plus datapath.
//
//   Port group          Dir   Handshake            Contents
//   command             in    start / busy         i_action, i_record_data, i_request_count
//   result              out   o_valid strobe       entry, sequence, session, counts, flags
//
// Record, clear, enable, disable and unused codes give a single result beat, which appears
// the cycle after acceptance, and a new command can be taken every cycle.
// Dump emits its N entries right after acceptance, drain after its catch-up, size and plan steps,
// one beat per cycle, set by the single read port of the ring memory and its registered read.
// The last beat of a run shows while busy is already low, so the next command overlaps it.
// Synchronous active-low reset clears the sequence, counters, cursor, session and enable
// flag; the ring contents are not cleared. The receiver cannot stall the result beats.
module overwriting_trace_ring_journal_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [otrj_pkg::ACT_W-1:0]  i_action,
    input  logic [otrj_pkg::DATA_W-1:0] i_record_data,
    input  logic [otrj_pkg::REQ_W-1:0]  i_request_count,
    output logic                        o_valid,
    output logic                        o_has_entry,
    output logic [otrj_pkg::DATA_W-1:0] o_entry_data,
    output logic [otrj_pkg::SEQ_W-1:0]  o_entry_sequence,
    output logic [otrj_pkg::SES_W-1:0]  o_session,
    output logic                        o_last,
    output logic [otrj_pkg::CNT_W-1:0]  o_emitted_total,
    output logic [otrj_pkg::CNT_W-1:0]  o_stored_count,
    output logic [otrj_pkg::DROP_W-1:0] o_dropped_total,
    output logic                        o_is_enabled
);
    import otrj_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    otrj_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    otrj_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_action         (i_action),
        .i_record_data    (i_record_data),
        .i_request_count  (i_request_count),
        .o_stat           (stat),
        .o_valid          (o_valid),
        .o_has_entry      (o_has_entry),
        .o_entry_data     (o_entry_data),
        .o_entry_sequence (o_entry_sequence),
        .o_session        (o_session),
        .o_last           (o_last),
        .o_emitted_total  (o_emitted_total),
        .o_stored_count   (o_stored_count),
        .o_dropped_total  (o_dropped_total),
        .o_is_enabled     (o_is_enabled)
    );
endmodule

@@ tb/overwriting_trace_ring_journal_top_tb.sv @@
// Self-checking testbench for the overwriting trace ring journal top level.

localparam logic [otrj_pkg::ACT_W-1:0] SPARE_CODE_A = 3'd6;
localparam logic [otrj_pkg::ACT_W-1:0] SPARE_CODE_B = 3'd7;

typedef struct packed {
    logic                        has_entry;
    logic [otrj_pkg::DATA_W-1:0] data;
    logic [otrj_pkg::SEQ_W-1:0]  seq;
    logic [otrj_pkg::SES_W-1:0]  session;
    logic                        last;
    logic [otrj_pkg::CNT_W-1:0]  emitted;
    logic [otrj_pkg::CNT_W-1:0]  stored;
    logic [otrj_pkg::DROP_W-1:0] dropped;
    logic                        enabled;
} t_trace_beat;

// Mirror of the journal state plus the beats that the accepted commands still owe.
class journal_mirror;
    t_trace_beat                 due_beats[$];
    logic [otrj_pkg::DATA_W-1:0] ring [otrj_pkg::DEPTH];
    logic [otrj_pkg::SEQ_W-1:0]  wr_seq;
    logic [otrj_pkg::CNT_W-1:0]  fill;
    logic [otrj_pkg::SEQ_W-1:0]  cursor;
    logic [otrj_pkg::DROP_W-1:0] drops;
    logic [otrj_pkg::SES_W-1:0]  session;
    logic                        enabled;
    int                          failures;
    int                          beats_seen;
    int                          cmd_count [8];
    int                          overwrites;
    int                          max_emitted;

    function new();
        foreach (ring[i]) ring[i] = '0;
        foreach (cmd_count[i]) cmd_count[i] = 0;
        wr_seq = '0;
        fill = '0;
        cursor = '0;
        drops = '0;
        session = '0;
        enabled = 1'b0;
        failures = 0;
        beats_seen = 0;
        overwrites = 0;
        max_emitted = 0;
    endfunction

    function int pending();
        return due_beats.size();
    endfunction

    function t_trace_beat make_beat(logic has, logic [otrj_pkg::SEQ_W-1:0] seq_no);
        t_trace_beat b;
        b.has_entry = has;
        b.data      = has ? ring[seq_no[otrj_pkg::ADDR_W-1:0]] : '0;
        b.seq       = has ? seq_no : '0;
        b.session   = session;
        b.last      = 1'b0;
        b.emitted   = '0;
        b.stored    = fill;
        b.dropped   = drops;
        b.enabled   = enabled;
        return b;
    endfunction

    function void take_command(logic [otrj_pkg::ACT_W-1:0] action,
                               logic [otrj_pkg::DATA_W-1:0] word,
                               logic [otrj_pkg::REQ_W-1:0] count);
        int                         n;
        int                         want;
        int                         i;
        logic [otrj_pkg::SEQ_W-1:0] ptr;
        logic [otrj_pkg::SEQ_W-1:0] oldest;
        t_trace_beat                b;
        n = 0;
        cmd_count[action]++;
        case (action)
            otrj_pkg::ACT_RECORD: begin
                if (enabled) begin
                    if (fill >= otrj_pkg::CNT_W'(otrj_pkg::DEPTH)) begin
                        overwrites++;
                        if (drops != '1) drops++;
                    end
                    ring[wr_seq[otrj_pkg::ADDR_W-1:0]] = word;
                    wr_seq++;
                    if (fill < otrj_pkg::CNT_W'(otrj_pkg::DEPTH)) fill++;
                end
            end
            otrj_pkg::ACT_DUMP: begin
                want = (count == 0 || int'(count) > int'(fill)) ? int'(fill) : int'(count);
                ptr = wr_seq - otrj_pkg::SEQ_W'(want);
                for (i = 0; i < want; i++) begin
                    due_beats.push_back(make_beat(1'b1, ptr));
                    ptr++;
                    n++;
                end
            end
            otrj_pkg::ACT_DRAIN: begin
                // The cursor is first pulled up past entries already overwritten.
                oldest = wr_seq - otrj_pkg::SEQ_W'(fill);
                if (cursor < oldest) cursor = oldest;
                while ((count == 0 || n < int'(count)) && cursor < wr_seq
                       && n < otrj_pkg::DEPTH) begin
                    due_beats.push_back(make_beat(1'b1, cursor));
                    cursor++;
                    n++;
                end
            end
            otrj_pkg::ACT_CLEAR: begin
                fill = '0;
                wr_seq = '0;
                cursor = '0;
                drops = '0;
            end
            otrj_pkg::ACT_ENABLE: begin
                if (!enabled) begin
                    session++;
                    if (session == 0) session = 1;
                    drops = '0;
                end
                enabled = 1'b1;
                cursor = wr_seq;
            end
            otrj_pkg::ACT_DISABLE: begin
                if (enabled) begin
                    fill = '0;
                    wr_seq = '0;
                    cursor = '0;
                end
                enabled = 1'b0;
            end
            default: ;
        endcase
        if (n == 0) begin
            b = make_beat(1'b0, '0);
        end else begin
            b = due_beats.pop_back();
            b.emitted = otrj_pkg::CNT_W'(n);
        end
        b.last = 1'b1;
        due_beats.push_back(b);
        if (n > max_emitted) max_emitted = n;
    endfunction

    function string beat_text(t_trace_beat b);
        return $sformatf("has=%0b data=%h seq=%0d ses=%0d last=%0b emit=%0d stored=%0d drop=%0d en=%0b",
                         b.has_entry, b.data, b.seq, b.session, b.last, b.emitted, b.stored,
                         b.dropped, b.enabled);
    endfunction

    function void match_beat(t_trace_beat got);
        t_trace_beat exp_b;
        string       diffs;
        beats_seen++;
        if (due_beats.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("ERROR: unexpected result beat %0d: %s", beats_seen, beat_text(got));
            return;
        end
        exp_b = due_beats.pop_front();
        diffs = "";
        if (got.has_entry !== exp_b.has_entry) diffs = {diffs, " has_entry"};
        if (got.data !== exp_b.data)           diffs = {diffs, " entry_data"};
        if (got.seq !== exp_b.seq)             diffs = {diffs, " entry_sequence"};
        if (got.session !== exp_b.session)     diffs = {diffs, " session"};
        if (got.last !== exp_b.last)           diffs = {diffs, " last"};
        if (got.emitted !== exp_b.emitted)     diffs = {diffs, " emitted_total"};
        if (got.stored !== exp_b.stored)       diffs = {diffs, " stored_count"};
        if (got.dropped !== exp_b.dropped)     diffs = {diffs, " dropped_total"};
        if (got.enabled !== exp_b.enabled)     diffs = {diffs, " is_enabled"};
        if (diffs != "") begin
            failures++;
            if (failures <= 10) begin
                $display("ERROR: beat %0d differs in%s", beats_seen, diffs);
                $display("  expected %s", beat_text(exp_b));
                $display("  actual   %s", beat_text(got));
            end
        end
    endfunction

    function void close_out();
        if (due_beats.size() != 0) begin
            failures++;
            $display("ERROR: %0d expected result beats never arrived", due_beats.size());
        end
    endfunction
endclass

module overwriting_trace_ring_journal_top_tb;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [otrj_pkg::ACT_W-1:0]  i_action;
    logic [otrj_pkg::DATA_W-1:0] i_record_data;
    logic [otrj_pkg::REQ_W-1:0]  i_request_count;
    logic                        o_valid;
    logic                        o_has_entry;
    logic [otrj_pkg::DATA_W-1:0] o_entry_data;
    logic [otrj_pkg::SEQ_W-1:0]  o_entry_sequence;
    logic [otrj_pkg::SES_W-1:0]  o_session;
    logic                        o_last;
    logic [otrj_pkg::CNT_W-1:0]  o_emitted_total;
    logic [otrj_pkg::CNT_W-1:0]  o_stored_count;
    logic [otrj_pkg::DROP_W-1:0] o_dropped_total;
    logic                        o_is_enabled;

    journal_mirror sb;

    overwriting_trace_ring_journal_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_record_data    (i_record_data),
        .i_request_count  (i_request_count),
        .o_valid          (o_valid),
        .o_has_entry      (o_has_entry),
        .o_entry_data     (o_entry_data),
        .o_entry_sequence (o_entry_sequence),
        .o_session        (o_session),
        .o_last           (o_last),
        .o_emitted_total  (o_emitted_total),
        .o_stored_count   (o_stored_count),
        .o_dropped_total  (o_dropped_total),
        .o_is_enabled     (o_is_enabled)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Timeout: the journal stopped making progress");
        $display("Simulation FAILED");
        $finish;
    end

    // Result beats are checked before a command taken on the same edge adds its own beats.
    always @(posedge i_clk) begin : watch_ports
        t_trace_beat got;
        if (i_rst_n === 1'b1) begin
            if (o_valid === 1'b1) begin
                got.has_entry = o_has_entry;
                got.data      = o_entry_data;
                got.seq       = o_entry_sequence;
                got.session   = o_session;
                got.last      = o_last;
                got.emitted   = o_emitted_total;
                got.stored    = o_stored_count;
                got.dropped   = o_dropped_total;
                got.enabled   = o_is_enabled;
                sb.match_beat(got);
            end
            if (start && !busy)
                sb.take_command(i_action, i_record_data, i_request_count);
        end
    end

    // Leaves start high so that back-to-back commands need no gap.
    task automatic issue(input logic [otrj_pkg::ACT_W-1:0] act,
                         input logic [otrj_pkg::DATA_W-1:0] word,
                         input logic [otrj_pkg::REQ_W-1:0] count);
        i_action        <= act;
        i_record_data   <= word;
        i_request_count <= count;
        start           <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic logic [otrj_pkg::REQ_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return '0;
        if (r < 8) return otrj_pkg::REQ_W'($urandom_range(1, 8));
        if (r < 9) return otrj_pkg::REQ_W'($urandom_range(9, 70));
        return otrj_pkg::REQ_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [otrj_pkg::DATA_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    initial begin : stimulus
        int                         n_rand;
        int                         r;
        int                         burst_left;
        int                         guard;
        logic [otrj_pkg::ACT_W-1:0] act;
        sb = new();
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_action        <= otrj_pkg::ACT_RECORD;
        i_record_data   <= '0;
        i_request_count <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty ring, unused codes, small contents, clear, disable and re-enable.
        issue(otrj_pkg::ACT_RECORD, '1, '0);
        issue(otrj_pkg::ACT_DUMP, '0, '0);
        issue(otrj_pkg::ACT_DRAIN, '0, '0);
        issue(SPARE_CODE_A, '1, '1);
        issue(SPARE_CODE_B, '0, '0);
        issue(otrj_pkg::ACT_ENABLE, '0, '0);
        issue(otrj_pkg::ACT_ENABLE, '0, '0);
        issue(otrj_pkg::ACT_RECORD, '0, '0);
        issue(otrj_pkg::ACT_RECORD, '1, '1);
        pause(3);
        issue(otrj_pkg::ACT_RECORD, 64'hA5A5_5A5A_0F0F_F0F0, 16'h5A5A);
        issue(otrj_pkg::ACT_DUMP, '0, '0);
        issue(otrj_pkg::ACT_DUMP, '0, 16'd1);
        issue(otrj_pkg::ACT_DUMP, '0, 16'hFFFF);
        issue(otrj_pkg::ACT_DRAIN, '0, 16'd1);
        issue(otrj_pkg::ACT_DRAIN, '0, '0);
        issue(otrj_pkg::ACT_DRAIN, '0, '0);
        issue(otrj_pkg::ACT_CLEAR, '0, '0);
        issue(otrj_pkg::ACT_DUMP, '0, '0);
        issue(otrj_pkg::ACT_RECORD, 64'h0123_4567_89AB_CDEF, '0);
        issue(otrj_pkg::ACT_DISABLE, '0, '0);
        issue(otrj_pkg::ACT_RECORD, 64'hDEAD_BEEF_0000_0001, '0);
        issue(otrj_pkg::ACT_DUMP, '0, '0);
        issue(otrj_pkg::ACT_ENABLE, '0, '0);
        issue(otrj_pkg::ACT_DRAIN, '0, 16'hFFFF);
        wait_quiet();

        // Random: record bursts that fill and wrap the ring, mixed with readouts and control.
        n_rand = 0;
        burst_left = 0;
        while (n_rand < 470) begin
            r = $urandom_range(0, 99);
            if (burst_left > 0) begin
                act = otrj_pkg::ACT_RECORD;
                burst_left--;
            end else if (!sb.enabled && r < 85) begin
                act = otrj_pkg::ACT_ENABLE;
            end else if (r < 35) begin
                act = otrj_pkg::ACT_RECORD;
                burst_left = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12)
                                                        : $urandom_range(20, 80);
            end else if (r < 55) begin
                act = otrj_pkg::ACT_DUMP;
            end else if (r < 75) begin
                act = otrj_pkg::ACT_DRAIN;
            end else if (r < 82) begin
                act = otrj_pkg::ACT_ENABLE;
            end else if (r < 87) begin
                act = otrj_pkg::ACT_CLEAR;
            end else if (r < 91) begin
                act = otrj_pkg::ACT_DISABLE;
            end else if (r < 94) begin
                act = r[0] ? SPARE_CODE_A : SPARE_CODE_B;
            end else begin
                act = otrj_pkg::ACT_RECORD;
            end
            if (!(act == otrj_pkg::ACT_RECORD && !sb.enabled)) n_rand++;
            issue(act, pick_word(), pick_count());
            if (n_rand == 200) begin
                wait_quiet();
            end else if (n_rand < 410 && $urandom_range(0, 3) == 0) begin
                pause($urandom_range(1, 13));
            end
        end

        start <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 1000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        sb.close_out();
        $display("Commands: %0d record, %0d dump, %0d drain, %0d clear, %0d enable, %0d disable",
                 sb.cmd_count[otrj_pkg::ACT_RECORD], sb.cmd_count[otrj_pkg::ACT_DUMP],
                 sb.cmd_count[otrj_pkg::ACT_DRAIN], sb.cmd_count[otrj_pkg::ACT_CLEAR],
                 sb.cmd_count[otrj_pkg::ACT_ENABLE], sb.cmd_count[otrj_pkg::ACT_DISABLE]);
        $display("%0d unused codes, %0d full-ring overwrites, %0d beats, longest readout %0d",
                 sb.cmd_count[SPARE_CODE_A] + sb.cmd_count[SPARE_CODE_B], sb.overwrites,
                 sb.beats_seen, sb.max_emitted);
        if (sb.failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/otrj_pkg.sv
rtl/otrj_ram.sv
rtl/otrj_ctrl.sv
rtl/otrj_dp.sv
rtl/overwriting_trace_ring_journal_top.sv
tb/overwriting_trace_ring_journal_top_tb.sv
